// ----- src/hwei_pkg.sv -----
// Package for the hashed word episode index: constants, types, hash fold.
`timescale 1ns / 1ps
package hwei_pkg;

  localparam int unsigned TableSizeDef   = 10000;
  localparam int unsigned MaxEpisodesDef = 64;
  localparam int unsigned MaxResults     = 64;
  localparam int unsigned ModChunkBits   = 16;
  localparam int unsigned HashWidth      = 64;

  localparam logic [HashWidth-1:0] HashInit  = 64'd5381;
  localparam logic [7:0]           SpaceByte = 8'h20;

  localparam logic CmdIndex = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic RegEpisodeCount = 1'b0;
  localparam logic RegResultLimit  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] character;
    logic [6:0] episode;
    logic       last;
  } hwei_req_t;

  typedef struct packed {
    logic [6:0] episode_number;
    logic       end_of_list;
  } hwei_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_WRITE,
    ST_SCAN
  } hwei_state_e;

  typedef struct packed {
    logic accept;
    logic clear_en;
    logic mod_step;
    logic mem_rd;
    logic mem_wr;
    logic scan_step;
    logic emit_hit;
    logic emit_term;
  } hwei_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic word_end;
    logic query;
    logic mod_done;
    logic scan_end;
    logic hit;
    logic full;
  } hwei_status_t;

  // h * 33 + signed byte, wrapping
  function automatic logic [HashWidth-1:0] hwei_fold(input logic [HashWidth-1:0] h,
                                                     input logic [7:0] c);
    return (h << 5) + h + {{(HashWidth-8){c[7]}}, c};
  endfunction

endpackage

// ----- src/hashed_word_episode_index.sv -----
// Top level of the hashed word episode index: register port, controller, datapath.
`timescale 1ns / 1ps
// Bytes are hashed with djb2 into a 64-bit word hash. Index mode: a space
// ends the word and sets the episode bit in bitmap row (hash mod TABLE_SIZE).
// Query mode: the byte marked last ends the word and the row is scanned,
// one episode per cycle, each set bit giving one result, at most the result
// limit less one, and a terminator closing the list. After reset the bitmap
// memory is cleared one row per cycle while busy is high; registers stay
// writable. A plain byte is folded into the hash while busy stays low.
// A word end keeps busy high through the remainder unit (chunk fold,
// reciprocal multiply, multiply back and subtract), a memory read, then a
// row write (index) or a scan of up to min(episode_count, MAX_EPISODES)
// episodes (query). Each result is on res_o for one cycle with res_valid_o
// high; the receiver must take it then, as it cannot stall.
module hashed_word_episode_index
  import hwei_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = TableSizeDef,
  parameter int unsigned MAX_EPISODES = MaxEpisodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  hwei_req_t   req_i,
  output logic        res_valid_o,
  output hwei_res_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]   episode_count_q;
  logic [6:0]   result_limit_q;
  logic         reg_wr;
  hwei_cmd_t    cmd;
  hwei_status_t status;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      episode_count_q <= 7'd5;
      result_limit_q  <= 7'd10;
    end else if (reg_wr) begin
      case (paddr[2])
        RegEpisodeCount: episode_count_q <= pwdata[6:0];
        RegResultLimit:  result_limit_q  <= pwdata[6:0];
        default: begin
          episode_count_q <= episode_count_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegEpisodeCount: prdata = {25'd0, episode_count_q};
      RegResultLimit:  prdata = {25'd0, result_limit_q};
      default:         prdata = '0;
    endcase
  end

  hwei_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  hwei_dp #(
    .TABLE_SIZE   (TABLE_SIZE),
    .MAX_EPISODES (MAX_EPISODES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .episode_count_i (episode_count_q),
    .result_limit_i  (result_limit_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .res_valid_o     (res_valid_o),
    .res_o           (res_o)
  );

endmodule

// ----- src/hwei_ctrl.sv -----
// Controller state machine for the hashed word episode index.
`timescale 1ns / 1ps
module hwei_ctrl
  import hwei_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  hwei_status_t status_i,
  output hwei_cmd_t    cmd_o,
  output logic         busy_o
);

  hwei_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i && status_i.word_end) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (status_i.mod_done) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = status_i.query ? ST_SCAN : ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.scan_end || (status_i.hit && status_i.full)) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
      end
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.mem_wr = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_end || (status_i.hit && status_i.full)) begin
          cmd_o.emit_term = 1'b1;
        end else if (status_i.hit) begin
          cmd_o.emit_hit = 1'b1;
        end
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

`ifndef SYNTH
  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |=> state_q == ST_SCAN || state_q == ST_IDLE)
    else $error("scan left to a state other than idle");

  a_term_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_term |=> state_q == ST_IDLE)
    else $error("terminator not followed by idle");

  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == (state_q != ST_IDLE))
    else $error("busy does not match idle state");
`endif

endmodule

// ----- src/hwei_dp.sv -----
// Datapath: hash register, modulo unit, bitmap memory, scan counters, result register.
`timescale 1ns / 1ps
module hwei_dp
  import hwei_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = TableSizeDef,
  parameter int unsigned MAX_EPISODES = MaxEpisodesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hwei_req_t    req_i,
  input  logic [6:0]   episode_count_i,
  input  logic [6:0]   result_limit_i,
  input  hwei_cmd_t    cmd_i,
  output hwei_status_t status_o,
  output logic         res_valid_o,
  output hwei_res_t    res_o
);

  localparam int unsigned ROW_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned EPI_W     = (MAX_EPISODES > 1) ? $clog2(MAX_EPISODES) : 1;
  localparam int unsigned MOD_STEPS = 3;
  localparam int unsigned CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int unsigned PROD_W    = ModChunkBits + ROW_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned QUO_W     = SUM_W + 1 - ROW_W;
  localparam logic [63:0]      TsL      = 64'(TABLE_SIZE);
  localparam logic [ROW_W-1:0] Res0     = ROW_W'(64'd1 % TsL);
  localparam logic [ROW_W-1:0] Res1     = ROW_W'((64'd1 << ModChunkBits) % TsL);
  localparam logic [ROW_W-1:0] Res2     = ROW_W'((64'd1 << (2 * ModChunkBits)) % TsL);
  localparam logic [ROW_W-1:0] Res3     = ROW_W'((64'd1 << (3 * ModChunkBits)) % TsL);
  localparam logic [63:0]      RecipL   = ((64'd1 << (SUM_W + ROW_W)) + TsL - 64'd1) / TsL;
  localparam logic [SUM_W:0]   Recip    = RecipL[SUM_W:0];
  localparam logic [SUM_W-1:0] TsS      = SUM_W'(TABLE_SIZE);
  localparam logic [ROW_W-1:0] LastRow  = ROW_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(MOD_STEPS - 1);
  localparam logic [6:0]       MaxEpV   = 7'(MAX_EPISODES);
  localparam logic [6:0]       MaxResV  = 7'(MaxResults);

  logic [HashWidth-1:0]    hash_q, hash_d, folded;
  logic [HashWidth-1:0]    dvd_q;
  logic [PROD_W-1:0]       p0, p1, p2, p3;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [2*SUM_W:0]        recip_prod;
  logic [QUO_W-1:0]        quo_q, quo_d;
  logic [SUM_W-1:0]        back, diff;
  logic [ROW_W-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]        cnt_q;
  logic [ROW_W-1:0]        clr_q;
  logic                    query_q;
  logic                    ep_ok_q;
  logic [EPI_W-1:0]        ep_idx_q;
  logic [MAX_EPISODES-1:0] row_q;
  logic [MAX_EPISODES-1:0] mask;
  logic [MAX_EPISODES-1:0] bitmap_mem [TABLE_SIZE];
  logic [ROW_W-1:0]        waddr;
  logic [MAX_EPISODES-1:0] wdata;
  logic                    we;
  logic [6:0]              e_q, n_q;
  logic [6:0]              eps, lim;
  logic                    word_end;
  logic                    res_valid_q;
  hwei_res_t               res_q;

  assign folded   = hwei_fold(hash_q, req_i.character);
  assign word_end = (req_i.command == CmdIndex) ? (req_i.character == SpaceByte)
                                                : req_i.last;
  assign eps = (episode_count_i > MaxEpV) ? MaxEpV : episode_count_i;
  assign lim = (result_limit_i == 7'd0)   ? 7'd1 :
               (result_limit_i > MaxResV) ? MaxResV : result_limit_i;

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.accept) begin
      if (word_end) begin
        hash_d = HashInit;
      end else begin
        hash_d = folded;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashInit;
      clr_q  <= '0;
    end else begin
      hash_q <= hash_d;
      if (cmd_i.clear_en && clr_q != LastRow) clr_q <= clr_q + 1'b1;
    end
  end

  // remainder by TABLE_SIZE: fold 16-bit chunks by their residues, then
  // reciprocal multiply for the quotient, then multiply back and subtract
  assign p0 = PROD_W'(dvd_q[ModChunkBits-1:0]) * PROD_W'(Res0);
  assign p1 = PROD_W'(dvd_q[2*ModChunkBits-1:ModChunkBits]) * PROD_W'(Res1);
  assign p2 = PROD_W'(dvd_q[3*ModChunkBits-1:2*ModChunkBits]) * PROD_W'(Res2);
  assign p3 = PROD_W'(dvd_q[4*ModChunkBits-1:3*ModChunkBits]) * PROD_W'(Res3);
  assign sum_d = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + SUM_W'(p3);

  assign recip_prod = (2*SUM_W+1)'(sum_q) * (2*SUM_W+1)'(Recip);
  assign quo_d      = recip_prod[2*SUM_W:SUM_W+ROW_W];
  assign back       = SUM_W'(quo_q) * TsS;
  assign diff       = sum_q - back;
  assign rem_d      = diff[ROW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && word_end) begin
      dvd_q    <= (req_i.command == CmdIndex) ? hash_q : folded;
      cnt_q    <= '0;
      query_q  <= (req_i.command == CmdQuery);
      ep_ok_q  <= (req_i.episode != 7'd0) && (req_i.episode <= eps);
      ep_idx_q <= EPI_W'(req_i.episode - 7'd1);
    end else if (cmd_i.mod_step) begin
      sum_q <= sum_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_EPISODES; i++) begin
      mask[i] = ep_ok_q && (ep_idx_q == EPI_W'(i));
    end
  end

  assign we    = cmd_i.clear_en || cmd_i.mem_wr;
  assign waddr = cmd_i.clear_en ? clr_q : rem_q;
  assign wdata = cmd_i.clear_en ? '0 : (row_q | mask);

  always_ff @(posedge clk_i) begin
    if (we) bitmap_mem[waddr] <= wdata;
    if (cmd_i.mem_rd) row_q <= bitmap_mem[rem_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      e_q <= '0;
      n_q <= '0;
    end else begin
      if (cmd_i.scan_step) e_q <= e_q + 7'd1;
      if (cmd_i.emit_hit)  n_q <= n_q + 7'd1;
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.clear_done = (clr_q == LastRow);
    status_o.word_end   = word_end;
    status_o.query      = query_q;
    status_o.mod_done   = (cnt_q == LastStep);
    status_o.scan_end   = (e_q >= eps);
    status_o.hit        = !status_o.scan_end && row_q[e_q[EPI_W-1:0]];
    status_o.full       = (n_q >= (lim - 7'd1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_hit || cmd_i.emit_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_term) begin
      res_q.episode_number <= '0;
      res_q.end_of_list    <= 1'b1;
    end else if (cmd_i.emit_hit) begin
      res_q.episode_number <= e_q + 7'd1;
      res_q.end_of_list    <= 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_term_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.end_of_list |=> !res_valid_q)
    else $error("result right after terminator");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.end_of_list |-> res_q.episode_number != 7'd0)
    else $error("episode result with number zero");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_wr |-> $past(cmd_i.mem_rd))
    else $error("row write without preceding row read");
`endif

endmodule

// ----- verif/hashed_word_episode_index_tb.sv -----
// Testbench for the hashed word episode index: directed table, random word traffic, predictor.
`timescale 1ns / 1ps
module hashed_word_episode_index_tb;
  import hwei_pkg::*;

  localparam int unsigned RowCount    = TableSizeDef;
  localparam int          DrainCycles = 120;
  localparam int          CycleLimit  = 400000;
  localparam int          PhaseItems  = 13;
  localparam int          VocabWords  = 8;

  localparam logic [2:0] AddrEpisodeCount = {RegEpisodeCount, 2'b00};
  localparam logic [2:0] AddrResultLimit  = {RegResultLimit, 2'b00};

  localparam hwei_res_t NoTyped  = '0;
  localparam hwei_res_t TermOnly = '{episode_number: 7'd0, end_of_list: 1'b1};

  typedef struct packed {
    hwei_req_t r;
    logic      typed_valid;
    hwei_res_t typed;
  } stim_row_t;

  // one request per row; only the first has its list typed in
  localparam stim_row_t DirectedRows [24] = '{
    '{'{CmdQuery, 8'h61, 7'd1, 1'b1}, 1'b1, TermOnly},   // empty bitmap after reset
    '{'{CmdIndex, 8'h61, 7'd1, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'h62, 7'd1, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, SpaceByte, 7'd1, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'h61, 7'd5, 1'b1}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'h62, 7'd5, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, SpaceByte, 7'd5, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, SpaceByte, 7'd3, 1'b0}, 1'b0, NoTyped},  // empty word
    '{'{CmdIndex, 8'h78, 7'd2, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'h00, 7'd2, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'hFF, 7'd2, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, SpaceByte, 7'd2, 1'b0}, 1'b0, NoTyped},
    '{'{CmdIndex, SpaceByte, 7'd127, 1'b1}, 1'b0, NoTyped},
    '{'{CmdIndex, SpaceByte, 7'd0, 1'b0}, 1'b0, NoTyped},
    '{'{CmdQuery, 8'h61, 7'd0, 1'b0}, 1'b0, NoTyped},
    '{'{CmdQuery, 8'h62, 7'd127, 1'b1}, 1'b0, NoTyped},
    '{'{CmdQuery, SpaceByte, 7'd64, 1'b1}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'h61, 7'd1, 1'b0}, 1'b0, NoTyped},     // word switches mode midway
    '{'{CmdQuery, 8'h62, 7'd1, 1'b1}, 1'b0, NoTyped},
    '{'{CmdQuery, 8'h78, 7'd9, 1'b0}, 1'b0, NoTyped},
    '{'{CmdQuery, 8'h00, 7'd9, 1'b0}, 1'b0, NoTyped},
    '{'{CmdQuery, 8'hFF, 7'd9, 1'b1}, 1'b0, NoTyped},
    '{'{CmdIndex, 8'h71, 7'd4, 1'b0}, 1'b0, NoTyped},     // trailing word runs on
    '{'{CmdQuery, 8'h71, 7'd4, 1'b1}, 1'b0, NoTyped}
  };

  localparam int PhaseCount = 6;
  localparam logic [6:0] PhaseEpisodeCount [PhaseCount] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd33};
  localparam logic [6:0] PhaseResultLimit  [PhaseCount] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd2};

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  hwei_req_t   req_i;
  logic        res_valid_o;
  hwei_res_t   res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hashed_word_episode_index u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor state
  logic [63:0] bitmap_rows [RowCount];
  logic [63:0] word_hash_q;
  logic [6:0]  episode_count_q;
  logic [6:0]  result_limit_q;
  hwei_res_t   episode_hits [$];
  hwei_res_t   pending_episodes [$];

  logic [7:0]  vocab [VocabWords][4];
  int          vocab_len [VocabWords];

  hwei_res_t   want;
  int          mismatches;
  int          requests_sent;
  int          lists_checked;
  int          results_checked;
  int          cycle_count;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_episodes.size());
      $display("hashed_word_episode_index_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_episodes.size() == 0) begin
        $display("%0t: unexpected result expected none, got episode_number=%0d end_of_list=%0b",
                 $time, res_o.episode_number, res_o.end_of_list);
        mismatches++;
      end else begin
        want = pending_episodes.pop_front();
        results_checked++;
        if (res_o.end_of_list === 1'b1) lists_checked++;
        if (res_o.episode_number !== want.episode_number ||
            res_o.end_of_list !== want.end_of_list) begin
          $display("%0t: result mismatch expected episode_number=%0d end_of_list=%0b, got %0d %0b",
                   $time, want.episode_number, want.end_of_list,
                   res_o.episode_number, res_o.end_of_list);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [63:0] djb2_step(input logic [63:0] h, input logic [7:0] c);
    return h * 64'd33 + {{56{c[7]}}, c};
  endfunction

  function automatic int active_episodes();
    return (episode_count_q > 7'd64) ? 64 : int'(episode_count_q);
  endfunction

  // updates the hash (and the bitmap on index) for one request, leaves any list in episode_hits
  task automatic index_or_lookup(input hwei_req_t r);
    int row_idx;
    int eps;
    int cap;
    int n;
    episode_hits.delete();
    eps = active_episodes();
    if (r.command == CmdIndex) begin
      if (r.character == SpaceByte) begin
        row_idx = int'(word_hash_q % 64'(RowCount));
        if (r.episode >= 7'd1 && int'(r.episode) <= eps)
          bitmap_rows[row_idx][r.episode - 7'd1] = 1'b1;
        word_hash_q = HashInit;
      end else begin
        word_hash_q = djb2_step(word_hash_q, r.character);
      end
    end else begin
      word_hash_q = djb2_step(word_hash_q, r.character);
      if (r.last) begin
        row_idx = int'(word_hash_q % 64'(RowCount));
        word_hash_q = HashInit;
        cap = int'(result_limit_q);
        if (cap < 1) cap = 1;
        if (cap > int'(MaxResults)) cap = int'(MaxResults);
        n = 0;
        for (int e = 1; e <= eps; e++) begin
          if (bitmap_rows[row_idx][e-1]) begin
            if (n >= cap - 1) break;
            episode_hits.push_back({7'(e), 1'b0});
            n++;
          end
        end
        episode_hits.push_back(TermOnly);
      end
    end
  endtask

  task automatic send_request(input hwei_req_t r, input logic typed_valid = 1'b0,
                              input hwei_res_t typed = '0);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    index_or_lookup(r);
    if (typed_valid) pending_episodes.push_back(typed);
    else foreach (episode_hits[i]) pending_episodes.push_back(episode_hits[i]);
    requests_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] addr, input logic [6:0] value);
    logic [31:0] rdata;
    apb_access(1'b0, addr, '0, rdata);
    if (rdata !== {25'd0, value}) begin
      $display("%0t: register 0x%0h expected %0d, got %0d", $time, addr, value, rdata);
      mismatches++;
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [6:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, addr, {25'($urandom), value}, rdata);
    if (addr == AddrEpisodeCount) episode_count_q = value;
    else result_limit_q = value;
    check_reg(addr, value);
  endtask

  task automatic wait_drained();
    forever begin
      @(posedge clk_i);
      if (pending_episodes.size() == 0 && !busy) break;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_random_sequence();
    hwei_req_t r;
    int pick;
    int w;
    int eff;
    logic [6:0] ep;
    pick = $urandom_range(0, 9);
    w    = $urandom_range(0, VocabWords - 1);
    eff  = active_episodes();
    if (eff < 1) eff = 1;
    if (pick < 6) begin
      ep = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, eff));
      for (int i = 0; i < vocab_len[w]; i++) begin
        r = '{CmdIndex, vocab[w][i], ep, 1'($urandom)};
        send_request(r);
      end
      r = '{CmdIndex, SpaceByte, ep, 1'($urandom)};
      send_request(r);
    end else if (pick < 9) begin
      for (int i = 0; i < vocab_len[w]; i++) begin
        r = '{CmdQuery, vocab[w][i], 7'($urandom), (i == vocab_len[w] - 1)};
        send_request(r);
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        r = '{1'($urandom), ($urandom_range(0, 3) == 0) ? SpaceByte : 8'($urandom),
              7'($urandom), 1'($urandom)};
        send_request(r);
      end
    end
  endtask

  initial begin
    int phase_base;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_i           = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    requests_sent   = 0;
    lists_checked   = 0;
    results_checked = 0;
    cycle_count     = 0;
    idle_on         = 1'b1;
    word_hash_q     = HashInit;
    episode_count_q = 7'd5;
    result_limit_q  = 7'd10;
    foreach (bitmap_rows[i]) bitmap_rows[i] = '0;
    for (int w = 0; w < VocabWords; w++) begin
      vocab_len[w] = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) begin
        vocab[w][i] = 8'($urandom);
        if (vocab[w][i] == SpaceByte) vocab[w][i] = 8'h21;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reg(AddrEpisodeCount, 7'd5);
    check_reg(AddrResultLimit, 7'd10);

    foreach (DirectedRows[i])
      send_request(DirectedRows[i].r, DirectedRows[i].typed_valid, DirectedRows[i].typed);

    for (int p = 0; p < PhaseCount; p++) begin
      @(negedge clk_i);
      start <= 1'b0;
      wait_drained();
      write_reg(AddrEpisodeCount, PhaseEpisodeCount[p]);
      write_reg(AddrResultLimit, PhaseResultLimit[p]);
      idle_on    = (p != 0);
      phase_base = requests_sent;
      while (requests_sent - phase_base < PhaseItems) send_random_sequence();
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait_drained();

    $display("Covered %0d requests over %0d register settings: %0d lists, %0d results checked.",
             requests_sent, PhaseCount + 1, lists_checked, results_checked);
    if (mismatches == 0) begin
      $display("hashed_word_episode_index_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("hashed_word_episode_index_tb failed");
    end
    $finish;
  end

endmodule
